### rtl/scrb_pkg.sv
// Package with the transaction types, register offsets and constants of the system config block.
package scrb_pkg;

    typedef struct packed {
        logic        req_type;
        logic [11:0] reg_offset;
        logic [31:0] write_data;
    } req_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        access_error;
    } rsp_t;

    localparam int OSC_SLOTS = 3;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_BOARD_INFO = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AUX_ID     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDENT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OSC0_INIT  = 3'd3;

    localparam logic [11:0] OFF_CFG_A       = 12'h000;
    localparam logic [11:0] OFF_LED_CFG     = 12'h004;
    localparam logic [11:0] OFF_SWITCHES    = 12'h00C;
    localparam logic [11:0] OFF_BOARD_INFO  = 12'h010;
    localparam logic [11:0] OFF_DATA_RETURN = 12'h0A0;
    localparam logic [11:0] OFF_DATA_OUT    = 12'h0A4;
    localparam logic [11:0] OFF_CONTROL     = 12'h0A8;
    localparam logic [11:0] OFF_STATUS      = 12'h0AC;
    localparam logic [11:0] OFF_DLL         = 12'h100;
    localparam logic [11:0] OFF_AUX_ID      = 12'hFF8;
    localparam logic [11:0] OFF_IDENT       = 12'hFFC;

    localparam logic [31:0] CTRL_RESET     = 32'h0010_0000;
    localparam logic [31:0] CTRL_KEEP_MASK = 32'h43F0_0FFF;
    localparam int          CTRL_START_BIT = 31;
    localparam int          CTRL_WRITE_BIT = 30;
    localparam logic [5:0]  FUNC_OSC       = 6'd1;
    localparam logic [31:0] DLL_FIXED      = 32'h00FF_0001;
    localparam logic [7:0]  LOCK_RESET     = 8'hFF;

    localparam logic [1:0] STAT_DONE  = 2'b01;
    localparam logic [1:0] STAT_ERROR = 2'b10;

    localparam logic [31:0] OSC_INIT_RESET [OSC_SLOTS] = '{
        32'd50000000, 32'd24576000, 32'd25000000
    };

endpackage

### rtl/system_config_register_block_core.sv
// Top level of the system config register block: bus decode, channel and register state.

// The block takes one bus transaction per clock cycle while the response side
// does not stall and returns one response transaction for each, in order. A
// transaction is captured in an input register, decoded and applied to the
// register state in a single pass, and its response is held in an output
// register, so a stalled response still lets one transaction be captured
// into an empty input register. A control word write with the start bit set
// runs its oscillator entry access in the same pass.
module system_config_register_block_core
    import scrb_pkg::*;
#(
    parameter int NUM_OSC = 3
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  req_t                 req,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output rsp_t                 rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    localparam int OSC_IDX_W = (NUM_OSC > 1) ? $clog2(NUM_OSC) : 1;

    logic        in_valid_reg;
    req_t        req_reg;
    logic        rsp_valid_reg;
    rsp_t        rsp_reg;
    rsp_t        rsp_next;

    logic [31:0] board_info_reg;
    logic [31:0] aux_id_reg;
    logic [31:0] ident_reg;
    logic [31:0] osc_init_reg [NUM_OSC];

    logic [31:0] cfg_a_reg, cfg_a_next;
    logic [31:0] led_cfg_reg, led_cfg_next;
    logic [31:0] data_return_reg, data_return_next;
    logic [31:0] data_out_reg, data_out_next;
    logic [31:0] control_reg, control_next;
    logic [1:0]  status_reg, status_next;
    logic [7:0]  lock_mask_reg, lock_mask_next;
    logic [31:0] osc_freq_reg [NUM_OSC];
    logic        osc_written_reg [NUM_OSC];

    logic                 advance;
    logic                 proc;
    logic                 freq_we;
    logic [OSC_IDX_W-1:0] dev_idx;
    logic [11:0]          device;
    logic [5:0]           func;
    logic                 entry_ok;
    logic [31:0]          entry_value;

    assign advance   = !rsp_valid_reg || rsp_ready;
    assign proc      = in_valid_reg && advance;
    assign req_ready = !in_valid_reg || advance;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign device      = req_reg.write_data[11:0];
    assign func        = req_reg.write_data[25:20];
    assign dev_idx     = device[OSC_IDX_W-1:0];
    assign entry_ok    = (func == FUNC_OSC) && (device < 12'(NUM_OSC));
    assign entry_value = osc_written_reg[dev_idx] ? osc_freq_reg[dev_idx]
                                                  : osc_init_reg[dev_idx];

    always_comb
    begin
        cfg_a_next       = cfg_a_reg;
        led_cfg_next     = led_cfg_reg;
        data_return_next = data_return_reg;
        data_out_next    = data_out_reg;
        control_next     = control_reg;
        status_next      = status_reg;
        lock_mask_next   = lock_mask_reg;
        freq_we          = 1'b0;
        rsp_next.read_data    = 32'd0;
        rsp_next.access_error = 1'b0;
        if (req_reg.req_type)
        begin
            unique case (req_reg.reg_offset)
                OFF_CFG_A:    cfg_a_next    = req_reg.write_data;
                OFF_LED_CFG:  led_cfg_next  = req_reg.write_data;
                OFF_DATA_OUT: data_out_next = req_reg.write_data;
                OFF_CONTROL:
                begin
                    status_next  = 2'b00;
                    control_next = req_reg.write_data & CTRL_KEEP_MASK;
                    if (req_reg.write_data[CTRL_START_BIT])
                    begin
                        status_next = STAT_DONE;
                        if (!entry_ok)
                        begin
                            status_next = STAT_DONE | STAT_ERROR;
                        end
                        else if (req_reg.write_data[CTRL_WRITE_BIT])
                        begin
                            freq_we = 1'b1;
                        end
                        else
                        begin
                            data_return_next = entry_value;
                        end
                    end
                end
                OFF_DLL:      lock_mask_next = req_reg.write_data[31:24];
                default:      rsp_next.access_error = 1'b1;
            endcase
        end
        else
        begin
            unique case (req_reg.reg_offset)
                OFF_CFG_A:       rsp_next.read_data = cfg_a_reg;
                OFF_LED_CFG:     rsp_next.read_data = led_cfg_reg;
                OFF_SWITCHES:    rsp_next.read_data = 32'd0;
                OFF_BOARD_INFO:  rsp_next.read_data = board_info_reg;
                OFF_DATA_RETURN: rsp_next.read_data = data_return_reg;
                OFF_DATA_OUT:    rsp_next.read_data = data_out_reg;
                OFF_CONTROL:     rsp_next.read_data = control_reg;
                OFF_STATUS:      rsp_next.read_data = {30'd0, status_reg};
                OFF_DLL:         rsp_next.read_data = {lock_mask_reg, 24'd0} | DLL_FIXED;
                OFF_AUX_ID:      rsp_next.read_data = aux_id_reg;
                OFF_IDENT:       rsp_next.read_data = ident_reg;
                default:         rsp_next.access_error = 1'b1;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (proc)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            req_reg <= req;
        end
        if (proc)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_a_reg       <= 32'd0;
            led_cfg_reg     <= 32'd0;
            data_return_reg <= 32'd0;
            data_out_reg    <= 32'd0;
            control_reg     <= CTRL_RESET;
            status_reg      <= 2'b00;
            lock_mask_reg   <= LOCK_RESET;
        end
        else if (proc)
        begin
            cfg_a_reg       <= cfg_a_next;
            led_cfg_reg     <= led_cfg_next;
            data_return_reg <= data_return_next;
            data_out_reg    <= data_out_next;
            control_reg     <= control_next;
            status_reg      <= status_next;
            lock_mask_reg   <= lock_mask_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            board_info_reg <= 32'd0;
            aux_id_reg     <= 32'd0;
            ident_reg      <= 32'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BOARD_INFO: board_info_reg <= cfg_data;
                CFG_AUX_ID:     aux_id_reg     <= cfg_data;
                CFG_IDENT:      ident_reg      <= cfg_data;
                default:        ;
            endcase
        end
    end

    for (genvar i = 0; i < NUM_OSC; i++)
    begin : g_osc
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                osc_init_reg[i]    <= OSC_INIT_RESET[i];
                osc_written_reg[i] <= 1'b0;
            end
            else
            begin
                if (cfg_we && (cfg_index == CFG_IDX_W'(int'(CFG_OSC0_INIT) + i)))
                begin
                    osc_init_reg[i] <= cfg_data;
                end
                if (proc && freq_we && (dev_idx == OSC_IDX_W'(i)))
                begin
                    osc_written_reg[i] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc && freq_we)
        begin
            osc_freq_reg[dev_idx] <= data_out_reg;
        end
    end

    a_write_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
        proc && req_reg.req_type |=> rsp_valid && (rsp.read_data == 32'd0))
        else $error("write response carries nonzero read data");

    a_error_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        status_reg[1] |-> status_reg[0])
        else $error("channel error without done");

    a_start_sets_done: assert property (@(posedge clk) disable iff (!rst_n)
        proc && req_reg.req_type && (req_reg.reg_offset == OFF_CONTROL)
        && req_reg.write_data[CTRL_START_BIT] |=> status_reg[0])
        else $error("started channel access did not report done");

    a_stalled_item_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(req_reg))
        else $error("captured transaction lost while response stalled");

    a_bad_status_write: assert property (@(posedge clk) disable iff (!rst_n)
        proc && req_reg.req_type && (req_reg.reg_offset == OFF_STATUS)
        |=> rsp.access_error && $stable(status_reg))
        else $error("write to status word was not rejected");

endmodule
